// ===== rtl/core/sced_pkg.sv =====
// ----------------------------------------------------------------------------
// sced_pkg
// Shared types, key codes and keymap tables for the scancode line editor.
// ----------------------------------------------------------------------------
package sced_pkg;

    // line length limit and counter width
    localparam int LINE_LIMIT = 255;
    localparam int LEN_W      = $clog2(LINE_LIMIT + 1);

    // key codes (set 1, make code without release bit)
    localparam logic [6:0] KEY_ESC     = 7'h01;
    localparam logic [6:0] KEY_BKSP    = 7'h0E;
    localparam logic [6:0] KEY_TAB     = 7'h0F;
    localparam logic [6:0] KEY_ENTER   = 7'h1C;
    localparam logic [6:0] KEY_CTRL    = 7'h1D;
    localparam logic [6:0] KEY_APOS    = 7'h27;
    localparam logic [6:0] KEY_GRAVE   = 7'h29;
    localparam logic [6:0] KEY_LSHIFT  = 7'h2A;
    localparam logic [6:0] KEY_COMMA   = 7'h2C;
    localparam logic [6:0] KEY_ACUTE   = 7'h2D;
    localparam logic [6:0] KEY_RSHIFT  = 7'h36;
    localparam logic [6:0] KEY_ALT     = 7'h38;
    localparam logic [6:0] KEY_CAPS    = 7'h3A;
    localparam logic [6:0] KEY_NUM     = 7'h45;
    localparam logic [6:0] KEY_SCROLL  = 7'h46;

    // characters
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TILDE   = 8'h7E;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_BACKTICK = 8'h60;
    localparam logic [7:0] CH_ACUTE   = 8'hB4;
    localparam logic [7:0] CH_LOW_A   = 8'h61;
    localparam logic [7:0] CH_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'h20;

    // line event codes
    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_SUBMIT = 2'd1;
    localparam logic [1:0] EV_CANCEL = 2'd2;

    // one echoed word with its marks
    typedef struct packed {
        logic [1:0] line_event;
        logic       removed;
        logic       appended;
        logic [7:0] echo_byte;
    } t_res;

    // decoded scancode: up to three words
    typedef struct packed {
        logic [1:0]     cnt;
        t_res [2:0]     res;
    } t_cmd;

    // push from the front end to the queue
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_push;

    // unshifted keymap
    localparam logic [7:0] TAB_NORMAL [64] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // shifted keymap
    localparam logic [7:0] TAB_SHIFT [64] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'hA8,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // key to character, with the abnt2 overrides
    function automatic logic [7:0] fn_lookup(input logic [6:0] key, input logic shift);
        logic [7:0] c;
        begin
            c = 8'h00;
            case (key)
                KEY_APOS:  c = shift ? 8'hC7 : 8'hE7;
                KEY_GRAVE: c = shift ? CH_CARET : CH_TILDE;
                KEY_COMMA: c = shift ? CH_TILDE : CH_CARET;
                KEY_ACUTE: c = shift ? CH_BACKTICK : CH_ACUTE;
                default: begin
                    if (!key[6]) begin
                        c = shift ? TAB_SHIFT[key[5:0]] : TAB_NORMAL[key[5:0]];
                    end
                end
            endcase
            return c;
        end
    endfunction

    // dead key mark
    function automatic logic fn_is_accent(input logic [7:0] c);
        return (c == CH_ACUTE) || (c == CH_BACKTICK) || (c == CH_CARET) || (c == CH_TILDE);
    endfunction

    // accent plus base letter, zero when the pair is unknown
    function automatic logic [7:0] fn_combine(input logic [7:0] base, input logic [7:0] acc);
        logic [7:0] r;
        begin
            r = 8'h00;
            case (acc)
                CH_ACUTE: begin
                    case (base)
                        8'h61:   r = 8'hE1;
                        8'h65:   r = 8'hE9;
                        8'h69:   r = 8'hED;
                        8'h6F:   r = 8'hF3;
                        8'h75:   r = 8'hFA;
                        default: r = 8'h00;
                    endcase
                end
                CH_BACKTICK: begin
                    case (base)
                        8'h61:   r = 8'hE0;
                        8'h65:   r = 8'hE8;
                        8'h69:   r = 8'hEC;
                        8'h6F:   r = 8'hF2;
                        8'h75:   r = 8'hF9;
                        default: r = 8'h00;
                    endcase
                end
                CH_CARET: begin
                    case (base)
                        8'h61:   r = 8'hE2;
                        8'h65:   r = 8'hEA;
                        8'h69:   r = 8'hEE;
                        8'h6F:   r = 8'hF4;
                        8'h75:   r = 8'hFB;
                        default: r = 8'h00;
                    endcase
                end
                CH_TILDE: begin
                    case (base)
                        8'h61:   r = 8'hE3;
                        8'h6F:   r = 8'hF5;
                        8'h6E:   r = 8'hF1;
                        default: r = 8'h00;
                    endcase
                end
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/scancode_to_char_line_editor.sv =====
// ----------------------------------------------------------------------------
// scancode_to_char_line_editor
// Set-1 scancode to Latin-1 line editor for an ABNT2 keyboard layout.
// ----------------------------------------------------------------------------
// A scancode byte is taken whenever the two-entry command queue has room,
// so bytes may arrive back to back. Each byte is decoded at once into zero
// to three echo words; these leave the output stage one per cycle while the
// receiver is ready, so a backspace that removes a byte gives three words,
// every other key at most two, and a key that echoes nothing adds no command.
// The result words of one scancode come out in order with tlast on the final
// one. Modifier, lock, dead-key and line length state is cleared by reset.
module scancode_to_char_line_editor
    import sced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] scan_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] echo_byte
    output logic [3:0] o_m_axis_tuser,   // [0] appended, [1] removed, [3:2] line_event
    output logic       o_m_axis_tlast
);

    t_push push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;
    t_cmd  q_head;

    // decode and state tracking
    sced_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_scan_byte (i_s_axis_tdata),
        .i_full      (q_full),
        .o_ready     (o_s_axis_tready),
        .o_push      (push)
    );

    // command queue
    sced_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // echo word sequencing
    sced_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .i_ready     (i_m_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .o_echo_byte (o_m_axis_tdata),
        .o_marks     (o_m_axis_tuser),
        .o_last      (o_m_axis_tlast)
    );

endmodule

// ===== rtl/core/sced_front.sv =====
// ----------------------------------------------------------------------------
// sced_front
// Accepts scancodes, tracks modifier, lock, accent and line state, and turns
// each scancode into a command of zero to three echo words.
// ----------------------------------------------------------------------------
module sced_front
    import sced_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_scan_byte,
    input  logic        i_full,
    output logic        o_ready,
    output t_push       o_push
);

    logic             r_shift, r_ctrl, r_alt;
    logic             r_caps, r_num, r_scroll;
    logic             r_pend;
    logic [7:0]       r_acc;
    logic [LEN_W-1:0] r_len;

    logic             n_shift, n_ctrl, n_alt;
    logic             n_caps, n_num, n_scroll;
    logic             n_pend;
    logic [7:0]       n_acc;
    logic [LEN_W-1:0] n_len;

    logic             accept;
    logic [6:0]       key;
    logic             pressed;
    logic [7:0]       c;
    logic [7:0]       c_up;
    logic [7:0]       comb;
    logic             c_lower;
    logic             room0;
    logic             room1;
    logic             acc_out;
    logic [LEN_W-1:0] len1;
    t_cmd             cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign key     = i_scan_byte[6:0];
    assign pressed = !i_scan_byte[7];

    // keymap and accent lookups
    assign c       = fn_lookup(key, r_shift);
    assign c_lower = (c >= CH_LOW_A) && (c <= CH_LOW_Z);
    assign comb    = (r_pend && c_lower) ? fn_combine(c, r_acc) : 8'h00;
    assign c_up    = (r_caps && !r_shift && c_lower) ? (c - CASE_DIFF) : c;
    assign room0   = r_len < LEN_W'(LINE_LIMIT);
    assign acc_out = r_pend && c_lower && (comb == 8'h00);
    assign len1    = (acc_out && room0) ? (r_len + LEN_W'(1)) : r_len;
    assign room1   = len1 < LEN_W'(LINE_LIMIT);

    // decode one scancode
    always_comb begin
        n_shift  = r_shift;
        n_ctrl   = r_ctrl;
        n_alt    = r_alt;
        n_caps   = r_caps;
        n_num    = r_num;
        n_scroll = r_scroll;
        n_pend   = r_pend;
        n_acc    = r_acc;
        n_len    = r_len;
        cmd      = '0;

        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
            n_shift = pressed;
        end else if (key == KEY_CTRL) begin
            n_ctrl = pressed;
        end else if (key == KEY_ALT) begin
            n_alt = pressed;
        end else if (pressed) begin
            if (key == KEY_CAPS) begin
                n_caps = !r_caps;
            end else if (key == KEY_NUM) begin
                n_num = !r_num;
            end else if (key == KEY_SCROLL) begin
                n_scroll = !r_scroll;
            end else if (key == KEY_ENTER || key == KEY_ESC) begin
                n_pend                  = 1'b0;
                n_len                   = '0;
                cmd.cnt                 = 2'd1;
                cmd.res[0].echo_byte    = CH_LF;
                cmd.res[0].line_event   = (key == KEY_ENTER) ? EV_SUBMIT : EV_CANCEL;
            end else if (key == KEY_BKSP) begin
                n_pend = 1'b0;
                if (r_len != '0) begin
                    n_len                = r_len - LEN_W'(1);
                    cmd.cnt              = 2'd3;
                    cmd.res[0].echo_byte = CH_BS;
                    cmd.res[0].removed   = 1'b1;
                    cmd.res[1].echo_byte = CH_SPACE;
                    cmd.res[2].echo_byte = CH_BS;
                end
            end else if (key == KEY_TAB) begin
                n_pend               = 1'b0;
                cmd.cnt              = 2'd1;
                cmd.res[0].echo_byte = CH_TAB;
                cmd.res[0].appended  = room0;
                n_len                = room0 ? (r_len + LEN_W'(1)) : r_len;
            end else begin
                // unknown accent pair: echo the accent first
                if (acc_out) begin
                    cmd.cnt              = 2'd1;
                    cmd.res[0].echo_byte = r_acc;
                    cmd.res[0].appended  = room0;
                end
                if (r_pend && c_lower) begin
                    n_pend = 1'b0;
                end
                n_len = len1;
                if (comb != 8'h00) begin
                    if (room0) begin
                        cmd.cnt              = 2'd1;
                        cmd.res[0].echo_byte = comb;
                        cmd.res[0].appended  = 1'b1;
                        n_len                = r_len + LEN_W'(1);
                    end
                end else if (!r_pend && fn_is_accent(c)) begin
                    n_pend = 1'b1;
                    n_acc  = c;
                end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                    if (room1) begin
                        n_len = len1 + LEN_W'(1);
                        if (acc_out) begin
                            cmd.cnt              = 2'd2;
                            cmd.res[1].echo_byte = c_up;
                            cmd.res[1].appended  = 1'b1;
                        end else begin
                            cmd.cnt              = 2'd1;
                            cmd.res[0].echo_byte = c_up;
                            cmd.res[0].appended  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign o_push.valid = accept && (cmd.cnt != 2'd0);
    assign o_push.cmd   = cmd;

    // editor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_alt    <= 1'b0;
            r_caps   <= 1'b0;
            r_num    <= 1'b0;
            r_scroll <= 1'b0;
            r_pend   <= 1'b0;
            r_acc    <= 8'h00;
            r_len    <= '0;
        end else if (accept) begin
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_alt    <= n_alt;
            r_caps   <= n_caps;
            r_num    <= n_num;
            r_scroll <= n_scroll;
            r_pend   <= n_pend;
            r_acc    <= n_acc;
            r_len    <= n_len;
        end
    end

endmodule

// ===== rtl/core/sced_queue.sv =====
// ----------------------------------------------------------------------------
// sced_queue
// Two-entry command queue between the decoding front end and the echo back end.
// ----------------------------------------------------------------------------
module sced_queue
    import sced_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_cmd  o_head
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (i_push.valid && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push.valid && do_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/sced_back.sv =====
// ----------------------------------------------------------------------------
// sced_back
// Walks the words of the head command one per cycle, unless the output
// stalls, into a registered output stage and marks each command's last word.
// ----------------------------------------------------------------------------
module sced_back
    import sced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_cmd       i_head,
    output logic       o_pop,
    input  logic       i_ready,
    output logic       o_valid,
    output logic [7:0] o_echo_byte,
    output logic [3:0] o_marks,
    output logic       o_last
);

    logic [1:0] r_idx;
    logic       r_valid;
    t_res       r_res;
    logic       r_last;

    logic       load;
    logic       is_last;
    t_res       cur;

    assign load    = i_valid && (!r_valid || i_ready);
    assign cur     = i_head.res[r_idx];
    assign is_last = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop   = load && is_last;

    // word index within the head command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 2'd0;
        end else if (load) begin
            r_idx <= is_last ? 2'd0 : (r_idx + 2'd1);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= cur;
            r_last <= is_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_echo_byte = r_res.echo_byte;
    assign o_marks     = {r_res.line_event, r_res.removed, r_res.appended};
    assign o_last      = r_last;

endmodule

// ===== tb/scancode_to_char_line_editor_checker.sv =====
// ----------------------------------------------------------------------------
// scancode_to_char_line_editor_checker
// Watches both stream channels of the line editor, decodes every accepted
// scancode into the echo words it must cause and compares each echo word
// field by field against the oldest one still pending.
// ----------------------------------------------------------------------------
module scancode_to_char_line_editor_checker
    import sced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_scan_tvalid,
    input  logic       i_scan_tready,
    input  logic [7:0] i_scan_tdata,    // [7:0] scan_byte
    input  logic       i_echo_tvalid,
    input  logic       i_echo_tready,
    input  logic [7:0] i_echo_tdata,    // [7:0] echo_byte
    input  logic [3:0] i_echo_tuser,    // [0] appended, [1] removed, [3:2] line_event
    input  logic       i_echo_tlast,
    output int         o_fail_count,
    output int         o_words_pending,
    output int         o_scan_count,
    output int         o_word_count
);
    timeunit 1ns;
    timeprecision 1ps;

    // one echo word as the editor should send it
    typedef struct packed {
        logic [7:0] echo_byte;
        logic       appended;
        logic       removed;
        logic [1:0] line_event;
        logic       last;
    } t_echo_word;

    // abnt2 keymaps, unshifted and shifted
    localparam logic [7:0] PLAIN_MAP [64] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
        8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
        8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
        8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [7:0] SHIFTED_MAP [64] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'hA8,
        8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
        8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
        8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00,
        8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // accented letters for a, e, i, o, u (and n for tilde)
    localparam logic [7:0] ACUTE_LETTERS [5] = '{8'hE1, 8'hE9, 8'hED, 8'hF3, 8'hFA};
    localparam logic [7:0] GRAVE_LETTERS [5] = '{8'hE0, 8'hE8, 8'hEC, 8'hF2, 8'hF9};
    localparam logic [7:0] CARET_LETTERS [5] = '{8'hE2, 8'hEA, 8'hEE, 8'hF4, 8'hFB};
    localparam logic [7:0] TILDE_LETTERS [6] = '{8'hE3, 8'h00, 8'h00, 8'hF5, 8'h00, 8'hF1};

    // editor state as the predictor sees it
    logic       shift_down;
    logic       ctrl_down;
    logic       alt_down;
    logic       caps_on;
    logic       num_on;
    logic       scroll_on;
    logic       accent_pending;
    logic [7:0] accent_byte;
    int         line_len;

    t_echo_word pending_echo[$];
    t_echo_word scan_words[$];
    t_echo_word want_word;

    int fail_count;
    int scan_count;
    int word_count;
    int words_pending;

    assign o_fail_count    = fail_count;
    assign o_words_pending = words_pending;
    assign o_scan_count    = scan_count;
    assign o_word_count    = word_count;

    // key to character with the abnt2 overrides
    function automatic logic [7:0] key_to_char(input logic [6:0] key, input logic shifted);
        logic [7:0] c;
        c = 8'h00;
        if (key == KEY_APOS) begin
            c = shifted ? 8'hC7 : 8'hE7;
        end else if (key == KEY_GRAVE) begin
            c = shifted ? CH_CARET : CH_TILDE;
        end else if (key == KEY_COMMA) begin
            c = shifted ? CH_TILDE : CH_CARET;
        end else if (key == KEY_ACUTE) begin
            c = shifted ? CH_BACKTICK : CH_ACUTE;
        end else if (key < 7'd64) begin
            c = shifted ? SHIFTED_MAP[key[5:0]] : PLAIN_MAP[key[5:0]];
        end
        return c;
    endfunction

    function automatic logic is_dead_mark(input logic [7:0] c);
        return (c == CH_ACUTE) || (c == CH_BACKTICK) || (c == CH_CARET) || (c == CH_TILDE);
    endfunction

    // accent over a lowercase letter, zero for a pair with no latin-1 letter
    function automatic logic [7:0] accent_letter(input logic [7:0] base, input logic [7:0] mark);
        logic [7:0] r;
        int         v;
        r = 8'h00;
        case (base)
            8'h61:   v = 0;
            8'h65:   v = 1;
            8'h69:   v = 2;
            8'h6F:   v = 3;
            8'h75:   v = 4;
            8'h6E:   v = 5;
            default: v = -1;
        endcase
        if (v >= 0) begin
            case (mark)
                CH_ACUTE:    if (v < 5) r = ACUTE_LETTERS[v];
                CH_BACKTICK: if (v < 5) r = GRAVE_LETTERS[v];
                CH_CARET:    if (v < 5) r = CARET_LETTERS[v];
                CH_TILDE:    r = TILDE_LETTERS[v];
                default:     r = 8'h00;
            endcase
        end
        return r;
    endfunction

    task automatic add_word(input logic [7:0] b, input logic app, input logic rem,
                            input logic [1:0] ev);
        t_echo_word w;
        w.echo_byte  = b;
        w.appended   = app;
        w.removed    = rem;
        w.line_event = ev;
        w.last       = 1'b0;
        scan_words.push_back(w);
    endtask

    // append to the line if it has room; echo anyway when asked to
    task automatic line_put(input logic [7:0] b, input logic echo_when_full);
        if (line_len < LINE_LIMIT) begin
            line_len++;
            add_word(b, 1'b1, 1'b0, EV_NONE);
        end else if (echo_when_full) begin
            add_word(b, 1'b0, 1'b0, EV_NONE);
        end
    endtask

    // decode one scancode into the echo words it causes
    task automatic decode_scan(input logic [7:0] sc);
        logic [6:0] key;
        logic       pressed;
        logic [7:0] c;
        logic [7:0] comb;
        key     = sc[6:0];
        pressed = !sc[7];
        scan_words.delete();
        if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
            shift_down = pressed;
        end else if (key == KEY_CTRL) begin
            ctrl_down = pressed;
        end else if (key == KEY_ALT) begin
            alt_down = pressed;
        end else if (!pressed) begin
            // other releases are ignored
        end else if (key == KEY_CAPS) begin
            caps_on = !caps_on;
        end else if (key == KEY_NUM) begin
            num_on = !num_on;
        end else if (key == KEY_SCROLL) begin
            scroll_on = !scroll_on;
        end else if (key == KEY_ENTER || key == KEY_ESC) begin
            accent_pending = 1'b0;
            add_word(CH_LF, 1'b0, 1'b0, (key == KEY_ENTER) ? EV_SUBMIT : EV_CANCEL);
            line_len = 0;
        end else if (key == KEY_BKSP) begin
            accent_pending = 1'b0;
            if (line_len > 0) begin
                line_len--;
                add_word(CH_BS, 1'b0, 1'b1, EV_NONE);
                add_word(CH_SPACE, 1'b0, 1'b0, EV_NONE);
                add_word(CH_BS, 1'b0, 1'b0, EV_NONE);
            end
        end else if (key == KEY_TAB) begin
            accent_pending = 1'b0;
            line_put(CH_TAB, 1'b1);
        end else begin
            c    = key_to_char(key, shift_down);
            comb = 8'h00;
            // pending accent meets a lowercase letter
            if (accent_pending && c >= CH_LOW_A && c <= CH_LOW_Z) begin
                comb = accent_letter(c, accent_byte);
                if (comb == 8'h00) line_put(accent_byte, 1'b1);
                accent_pending = 1'b0;
            end
            if (comb != 8'h00) begin
                line_put(comb, 1'b0);
            end else if (!accent_pending && is_dead_mark(c)) begin
                accent_pending = 1'b1;
                accent_byte    = c;
            end else if (c >= CH_SPACE && c <= CH_TILDE) begin
                if (caps_on && !shift_down && c >= CH_LOW_A && c <= CH_LOW_Z) c = c - CASE_DIFF;
                line_put(c, 1'b0);
            end
        end
        if (scan_words.size() > 0) scan_words[scan_words.size() - 1].last = 1'b1;
        foreach (scan_words[i]) pending_echo.push_back(scan_words[i]);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: echo word %0d, %s: got %02h, want %02h",
                 $time, word_count, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count    = 0;
        scan_count    = 0;
        word_count    = 0;
        words_pending = 0;
    end

    // scancode words feed the predictor first, then echo words are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shift_down     = 1'b0;
            ctrl_down      = 1'b0;
            alt_down       = 1'b0;
            caps_on        = 1'b0;
            num_on         = 1'b0;
            scroll_on      = 1'b0;
            accent_pending = 1'b0;
            accent_byte    = 8'h00;
            line_len       = 0;
            pending_echo.delete();
            words_pending  = 0;
        end else begin
            if (i_scan_tvalid && i_scan_tready) begin
                decode_scan(i_scan_tdata);
                scan_count++;
            end
            if (i_echo_tvalid && i_echo_tready) begin
                if (pending_echo.size() == 0) begin
                    report_mismatch("nothing pending, echo_byte", i_echo_tdata, 8'h00);
                end else begin
                    want_word = pending_echo.pop_front();
                    if (i_echo_tdata != want_word.echo_byte)
                        report_mismatch("echo_byte", i_echo_tdata, want_word.echo_byte);
                    if (i_echo_tuser[0] != want_word.appended)
                        report_mismatch("appended", 8'(i_echo_tuser[0]),
                                        8'(want_word.appended));
                    if (i_echo_tuser[1] != want_word.removed)
                        report_mismatch("removed", 8'(i_echo_tuser[1]),
                                        8'(want_word.removed));
                    if (i_echo_tuser[3:2] != want_word.line_event)
                        report_mismatch("line_event", 8'(i_echo_tuser[3:2]),
                                        8'(want_word.line_event));
                    if (i_echo_tlast != want_word.last)
                        report_mismatch("last", 8'(i_echo_tlast), 8'(want_word.last));
                end
                word_count++;
            end
            words_pending = pending_echo.size();
        end
    end

endmodule

// ===== tb/tb_scancode_to_char_line_editor.sv =====
// ----------------------------------------------------------------------------
// tb_scancode_to_char_line_editor
// Drives scancodes into the line editor: a directed pass over modifiers,
// locks, dead keys and line control, then random typing with dead-key
// pairs, noise bytes and random stalls on both channels. The checker beside
// the block does all prediction.
// ----------------------------------------------------------------------------
module tb_scancode_to_char_line_editor;
    timeunit 1ns;
    timeprecision 1ps;
    import sced_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_SCANS  = 168;
    localparam int DRAIN_CYCLES  = 16;

    // modifiers, locks, line control and dead-key cases
    localparam logic [7:0] DIRECTED_SCANS [32] = '{
        {1'b0, KEY_ENTER}, {1'b0, KEY_BKSP}, 8'h10, {1'b0, KEY_TAB},
        {1'b0, KEY_BKSP}, {1'b0, KEY_CAPS}, 8'h1E, {1'b0, KEY_LSHIFT},
        8'h1E, 8'h08, 8'h35, {1'b1, KEY_LSHIFT},
        {1'b0, KEY_CAPS}, {1'b0, KEY_ACUTE}, 8'h12, {1'b0, KEY_GRAVE},
        8'h10, {1'b0, KEY_COMMA}, 8'h02, {1'b0, KEY_COMMA},
        8'h18, {1'b0, KEY_APOS}, {1'b0, KEY_RSHIFT}, {1'b1, KEY_RSHIFT},
        {1'b0, KEY_CTRL}, {1'b1, KEY_CTRL}, {1'b0, KEY_ALT}, {1'b1, KEY_ALT},
        {1'b0, KEY_NUM}, {1'b0, KEY_SCROLL}, 8'hFF, {1'b0, KEY_ESC}
    };

    // a, e, i, o, u and n keys
    localparam logic [7:0] VOWEL_KEYS [6] = '{8'h1E, 8'h12, 8'h17, 8'h18, 8'h16, 8'h31};

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [3:0] m_tuser;
    logic       m_tlast;

    int fail_count;
    int words_pending;
    int scan_count;
    int word_count;
    int cycle_count = 0;
    logic quiet = 1'b0;

    always #5 i_clk = ~i_clk;

    scancode_to_char_line_editor i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    scancode_to_char_line_editor_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_scan_tvalid   (s_tvalid),
        .i_scan_tready   (s_tready),
        .i_scan_tdata    (s_tdata),
        .i_echo_tvalid   (m_tvalid),
        .i_echo_tready   (m_tready),
        .i_echo_tdata    (m_tdata),
        .i_echo_tuser    (m_tuser),
        .i_echo_tlast    (m_tlast),
        .o_fail_count    (fail_count),
        .o_words_pending (words_pending),
        .o_scan_count    (scan_count),
        .o_word_count    (word_count)
    );

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // receiver stalls at random unless in the quiet stretch
    always @(negedge i_clk) begin
        m_tready <= quiet || ($urandom_range(99) >= 19);
    end

    // one scancode word; starts and ends at a falling edge
    task automatic send_scan(input logic [7:0] sc);
        while (!quiet && $urandom_range(99) < 19) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sc;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] random_letter_key();
        case ($urandom_range(2))
            0:       return 8'($urandom_range(8'h10, 8'h19));
            1:       return 8'($urandom_range(8'h1E, 8'h26));
            default: return 8'($urandom_range(8'h2E, 8'h32));
        endcase
    endfunction

    // one random group: typing, a dead-key pair, modifiers, control or noise
    task automatic send_random_group();
        int   roll;
        logic shifted;
        roll = $urandom_range(99);
        if (roll < 35) begin
            send_scan(8'($urandom_range(2, 57)));
        end else if (roll < 50) begin
            shifted = ($urandom_range(3) == 0);
            if (shifted) send_scan({1'b0, KEY_LSHIFT});
            case ($urandom_range(2))
                0:       send_scan({1'b0, KEY_GRAVE});
                1:       send_scan({1'b0, KEY_COMMA});
                default: send_scan({1'b0, KEY_ACUTE});
            endcase
            if (shifted) send_scan({1'b1, KEY_LSHIFT});
            if ($urandom_range(3) != 0) send_scan(VOWEL_KEYS[$urandom_range(5)]);
            else send_scan(random_letter_key());
        end else if (roll < 58) begin
            case ($urandom_range(3))
                0:       send_scan({1'b0, KEY_LSHIFT});
                1:       send_scan({1'b1, KEY_LSHIFT});
                2:       send_scan({1'b1, KEY_RSHIFT});
                default: send_scan({1'b0, KEY_CAPS});
            endcase
        end else if (roll < 70) begin
            case ($urandom_range(5))
                0:       send_scan({1'b0, KEY_ENTER});
                1:       send_scan({1'b0, KEY_ESC});
                2, 3:    send_scan({1'b0, KEY_BKSP});
                default: send_scan({1'b0, KEY_TAB});
            endcase
        end else if (roll < 80) begin
            send_scan({1'b1, 7'($urandom_range(127))});
        end else begin
            send_scan(8'($urandom_range(255)));
        end
    endtask

    initial begin
        int sent;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass
        foreach (DIRECTED_SCANS[i]) send_scan(DIRECTED_SCANS[i]);

        // random typing, with a quiet stretch in the middle
        sent = scan_count;
        while (scan_count - sent < RANDOM_SCANS) begin
            quiet = (scan_count - sent >= 60) && (scan_count - sent < 120);
            send_random_group();
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        // drain
        while (words_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d scancodes: modifier, lock and line control keys,", scan_count);
        $display("dead-key pairs and random typing under stalls on both sides");
        $display("%0d echo words compared, %0d mismatches", word_count, fail_count);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
